// ===== rtl/shist_pkg.sv =====
package shist_pkg;

   localparam int NUM_DOMAINS_DEF = 2;
   localparam int NUM_FIELDS_DEF  = 40;
   localparam int NUM_BUCKETS_DEF = 48;

   localparam int DATA_W  = 64;
   localparam int PCT_W   = 7;
   localparam int BOUND_W = 47;
   localparam int PROD_W  = DATA_W + PCT_W;
   localparam int LEN_W   = 7;

   // percent scale and largest meaningful percentile
   localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
   localparam logic [PCT_W:0]   PCT_SCALE = 8'd100;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_OBSERVE = 2'd1,
      CMD_READ    = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic                domain;
      logic [5:0]          field;
      logic [DATA_W-1:0]   value;
      logic [DATA_W-1:0]   batch_gen;
      logic                use_last;
      logic [PCT_W-1:0]    percentile;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   total_sum;
      logic                seen_flag;
      logic [DATA_W-1:0]   sample_count;
      logic [BOUND_W-1:0]  quantile_bound;
      logic                quantile_valid;
      logic [DATA_W-1:0]   stored_generation;
      logic                range_error;
   } rsp_type;

   // number of significant bits of a word
   function automatic logic [LEN_W-1:0] bit_length(input logic [DATA_W-1:0] v);
      logic [LEN_W-1:0] len;
      len = '0;
      for (int i = 0; i < DATA_W; i++) begin
         if (v[i]) begin
            len = LEN_W'(i + 1);
         end
      end
      return len;
   endfunction

endpackage

// ===== rtl/shist_if.sv =====
interface shist_req_if;
   import shist_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface shist_rsp_if;
   import shist_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/shist_ram.sv =====
module shist_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/stat_counters_log2_histogram_core.sv =====
// flow: dispatch, batch sweep on a generation change, update read/write, sum read, walk 1,
//   prep, walk 2, response; reads skip the update, no walk 2 without samples or above 100
// a generation change first sweeps every field/bucket address of that domain's batch memories
// clear-everything sweeps every domain/field/bucket address of all memories
// reset: synchronous; starts the same full sweep, req_ch.ready stays low until done
// throughput: one transaction at a time, next accepted the cycle after the response is taken
module stat_counters_log2_histogram_core #(
   parameter int NUM_DOMAINS = shist_pkg::NUM_DOMAINS_DEF,
   parameter int NUM_FIELDS  = shist_pkg::NUM_FIELDS_DEF,
   parameter int NUM_BUCKETS = shist_pkg::NUM_BUCKETS_DEF
) (
   input logic        clock,
   input logic        reset,
   shist_req_if.sink   req_ch,
   shist_rsp_if.source rsp_ch
);
   import shist_pkg::*;

   localparam int DW  = (NUM_DOMAINS > 1) ? $clog2(NUM_DOMAINS) : 1;
   localparam int FW  = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
   localparam int BW  = $clog2(NUM_BUCKETS);
   localparam int SAW = DW + FW;
   localparam int HAW = SAW + BW;
   localparam int BAW = FW + BW;

   typedef enum logic [10:0] {
      S_CLRALL = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_DISP   = 11'b00000000100,
      S_CLRB   = 11'b00000001000,
      S_UPDRD  = 11'b00000010000,
      S_UPDWR  = 11'b00000100000,
      S_SUMRD  = 11'b00001000000,
      S_WALK1  = 11'b00010000000,
      S_PREP   = 11'b00100000000,
      S_WALK2  = 11'b01000000000,
      S_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_ff, rsp_in;
   logic                  busy_ff, busy_in;
   logic [HAW-1:0]        idx_ff, idx_in;
   logic [BW:0]           bk_ff, bk_in;
   logic [BW-1:0]         rbk_ff, rbk_in;
   logic                  rdv_ff, rdv_in;
   logic [BW-1:0]         abk_ff, abk_in;
   logic                  avl_ff, avl_in;
   logic [DATA_W-1:0]     acc_ff, acc_in;
   logic [DATA_W-1:0]     samples_ff, samples_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  found_ff, found_in;
   logic [BOUND_W-1:0]    bound_ff, bound_in;
   logic [DATA_W-1:0]     sum_ff, sum_in;
   logic [BW-1:0]         bkt_ff, bkt_in;
   logic [NUM_DOMAINS-1:0][DATA_W-1:0]     gen_ff, gen_in;
   logic [NUM_DOMAINS-1:0][NUM_FIELDS-1:0] rseen_ff, rseen_in;
   logic [NUM_DOMAINS-1:0][NUM_FIELDS-1:0] bseen_ff, bseen_in;

   // memory ports
   logic              csum_we, bsum_we, hist_we_r, hist_we_b;
   logic [SAW-1:0]    sum_wa, sum_ra;
   logic [HAW-1:0]    hist_wa, hist_ra;
   logic [DATA_W-1:0] csum_wd, bsum_wd, rhist_wd, bhist_wd;
   logic [DATA_W-1:0] csum_rd, bsum_rd, rhist_rd, bhist_rd;

   logic [DW-1:0]     dom;
   logic [FW-1:0]     fld;
   logic [DATA_W-1:0] hist_sel, walk_sum;
   logic [LEN_W-1:0]  len;
   logic              range_bad;
   logic [PROD_W-1:0] acc_scaled;
   logic              seen_bit;

   assign dom       = DW'(req_ff.domain);
   assign fld       = FW'(req_ff.field);
   assign hist_sel  = req_ff.use_last ? bhist_rd : rhist_rd;
   assign walk_sum  = acc_ff + hist_sel;
   assign len       = bit_length(req_ff.value);
   assign range_bad = (int'(req_ff.domain) >= NUM_DOMAINS) ||
                      (int'(req_ff.field) >= NUM_FIELDS);
   assign seen_bit  = req_ff.use_last ? bseen_ff[dom][fld] : rseen_ff[dom][fld];

   // running count times 100, compared against samples times percentile
   assign acc_scaled = PROD_W'(acc_ff) * PROD_W'(PCT_SCALE);

   function automatic logic [BOUND_W-1:0] bucket_bound(input logic [BW-1:0] b);
      logic [BOUND_W-1:0] r;
      if (int'(b) >= BOUND_W) begin
         r = '1;
      end else begin
         r = (BOUND_W'(1) << b) - BOUND_W'(1);
      end
      return r;
   endfunction

   shist_ram #(.WIDTH(DATA_W), .DEPTH(2 ** SAW)) u_csum (
      .clock(clock), .wr_en(csum_we), .wr_addr(sum_wa), .wr_data(csum_wd),
      .rd_addr(sum_ra), .rd_data(csum_rd));
   shist_ram #(.WIDTH(DATA_W), .DEPTH(2 ** SAW)) u_bsum (
      .clock(clock), .wr_en(bsum_we), .wr_addr(sum_wa), .wr_data(bsum_wd),
      .rd_addr(sum_ra), .rd_data(bsum_rd));
   shist_ram #(.WIDTH(DATA_W), .DEPTH(2 ** HAW)) u_rhist (
      .clock(clock), .wr_en(hist_we_r), .wr_addr(hist_wa), .wr_data(rhist_wd),
      .rd_addr(hist_ra), .rd_data(rhist_rd));
   shist_ram #(.WIDTH(DATA_W), .DEPTH(2 ** HAW)) u_bhist (
      .clock(clock), .wr_en(hist_we_b), .wr_addr(hist_wa), .wr_data(bhist_wd),
      .rd_addr(hist_ra), .rd_data(bhist_rd));

   // control sequencer and memory port steering
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      rsp_in     = rsp_ff;
      busy_in    = busy_ff;
      idx_in     = idx_ff;
      bk_in      = bk_ff;
      rbk_in     = rbk_ff;
      rdv_in     = rdv_ff;
      abk_in     = abk_ff;
      avl_in     = avl_ff;
      acc_in     = acc_ff;
      samples_in = samples_ff;
      prod_in    = prod_ff;
      found_in   = found_ff;
      bound_in   = bound_ff;
      sum_in     = sum_ff;
      bkt_in     = bkt_ff;
      gen_in     = gen_ff;
      rseen_in   = rseen_ff;
      bseen_in   = bseen_ff;

      csum_we    = 1'b0;
      bsum_we    = 1'b0;
      hist_we_r  = 1'b0;
      hist_we_b  = 1'b0;
      sum_ra     = {dom, fld};
      sum_wa     = {dom, fld};
      hist_ra    = {dom, fld, bkt_ff};
      hist_wa    = {dom, fld, bkt_ff};
      csum_wd    = csum_rd + req_ff.value;
      bsum_wd    = bsum_rd + req_ff.value;
      rhist_wd   = rhist_rd + DATA_W'(1);
      bhist_wd   = bhist_rd + DATA_W'(1);

      // response fields from the current view
      rsp_in.total_sum         = sum_ff;
      rsp_in.seen_flag         = seen_bit;
      rsp_in.sample_count      = samples_ff;
      rsp_in.quantile_bound    = '0;
      rsp_in.quantile_valid    = 1'b0;
      rsp_in.stored_generation = gen_ff[dom];
      rsp_in.range_error       = 1'b0;

      case (state_ff)
         S_CLRALL: begin
            csum_we   = 1'b1;
            bsum_we   = 1'b1;
            hist_we_r = 1'b1;
            hist_we_b = 1'b1;
            sum_wa    = idx_ff[SAW-1:0];
            hist_wa   = idx_ff;
            csum_wd   = '0;
            bsum_wd   = '0;
            rhist_wd  = '0;
            bhist_wd  = '0;
            idx_in    = idx_ff + HAW'(1);
            if (idx_ff == '1) begin
               state_in = busy_ff ? S_DISP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               req_in  = req_ch.payload;
               busy_in = 1'b1;
               if (req_ch.payload.cmd == CMD_CLEAR) begin
                  idx_in   = '0;
                  gen_in   = '0;
                  rseen_in = '0;
                  bseen_in = '0;
                  state_in = S_CLRALL;
               end else begin
                  state_in = S_DISP;
               end
            end
         end
         S_DISP: begin
            bkt_in = (int'(len) >= NUM_BUCKETS) ? BW'(NUM_BUCKETS - 1) : BW'(len);
            if (range_bad) begin
               rsp_in             = '0;
               rsp_in.range_error = 1'b1;
               state_in           = S_OUT;
            end else if (req_ff.cmd == CMD_ADD || req_ff.cmd == CMD_OBSERVE) begin
               if (gen_ff[dom] != req_ff.batch_gen) begin
                  gen_in[dom]   = req_ff.batch_gen;
                  bseen_in[dom] = '0;
                  idx_in        = '0;
                  state_in      = S_CLRB;
               end else begin
                  state_in = S_UPDRD;
               end
            end else begin
               state_in = S_SUMRD;
            end
         end
         S_CLRB: begin
            // zero the batch sums and batch histograms of the domain
            bsum_we   = 1'b1;
            hist_we_b = 1'b1;
            sum_wa    = {dom, idx_ff[FW-1:0]};
            hist_wa   = {dom, idx_ff[BAW-1:0]};
            bsum_wd   = '0;
            bhist_wd  = '0;
            idx_in    = idx_ff + HAW'(1);
            if (idx_ff[BAW-1:0] == '1) begin
               state_in = S_UPDRD;
            end
         end
         S_UPDRD: begin
            state_in = S_UPDWR;
         end
         S_UPDWR: begin
            csum_we        = 1'b1;
            bsum_we        = 1'b1;
            hist_we_r      = (req_ff.cmd == CMD_OBSERVE);
            hist_we_b      = (req_ff.cmd == CMD_OBSERVE);
            rseen_in[dom][fld] = 1'b1;
            bseen_in[dom][fld] = 1'b1;
            state_in       = S_SUMRD;
         end
         S_SUMRD: begin
            bk_in    = '0;
            rdv_in   = 1'b0;
            avl_in   = 1'b0;
            acc_in   = '0;
            state_in = S_WALK1;
         end
         S_WALK1, S_WALK2: begin
            hist_ra = {dom, fld, bk_ff[BW-1:0]};
            if (state_ff == S_WALK1) begin
               sum_in = req_ff.use_last ? bsum_rd : csum_rd;
            end
            if (int'(bk_ff) < NUM_BUCKETS) begin
               bk_in  = bk_ff + (BW + 1)'(1);
               rdv_in = 1'b1;
               rbk_in = bk_ff[BW-1:0];
            end else begin
               rdv_in = 1'b0;
            end
            avl_in = rdv_ff;
            abk_in = rbk_ff;
            if (rdv_ff) begin
               acc_in = walk_sum;
            end
            // running count through bucket abk_ff checked in the cycle after it is accumulated
            if (state_ff == S_WALK2 && avl_ff && !found_ff && acc_scaled >= prod_ff) begin
               found_in = 1'b1;
               bound_in = bucket_bound(abk_ff);
            end
            if (int'(bk_ff) == NUM_BUCKETS && !rdv_ff && !avl_ff) begin
               if (state_ff == S_WALK1) begin
                  state_in = S_PREP;
               end else begin
                  rsp_in.quantile_bound = found_ff ? bound_ff : '0;
                  rsp_in.quantile_valid = found_ff;
                  state_in              = S_OUT;
               end
            end
         end
         S_PREP: begin
            samples_in = acc_ff;
            rsp_in.sample_count = acc_ff;
            if (acc_ff == '0 || req_ff.percentile > PCT_MAX) begin
               state_in = S_OUT;
            end else begin
               prod_in  = PROD_W'(acc_ff) * PROD_W'(req_ff.percentile);
               bk_in    = '0;
               rdv_in   = 1'b0;
               avl_in   = 1'b0;
               acc_in   = '0;
               found_in = 1'b0;
               bound_in = '0;
               state_in = S_WALK2;
            end
         end
         S_OUT: begin
            rsp_in = rsp_ff;
            if (rsp_ch.ready) begin
               busy_in  = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // keep held response stable outside its build points
      if (state_ff != S_DISP && state_ff != S_PREP && state_ff != S_WALK2 &&
          state_ff != S_OUT) begin
         rsp_in = rsp_ff;
      end
      if (state_ff == S_PREP && state_in == S_WALK2) begin
         rsp_in = rsp_ff;
      end
      if (state_ff == S_WALK2 && state_in != S_OUT) begin
         rsp_in = rsp_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLRALL;
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         gen_ff   <= '0;
         rseen_ff <= '0;
         bseen_ff <= '0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         gen_ff   <= gen_in;
         rseen_ff <= rseen_in;
         bseen_ff <= bseen_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      bk_ff      <= bk_in;
      rbk_ff     <= rbk_in;
      rdv_ff     <= rdv_in;
      abk_ff     <= abk_in;
      avl_ff     <= avl_in;
      acc_ff     <= acc_in;
      samples_ff <= samples_in;
      prod_ff    <= prod_in;
      found_ff   <= found_in;
      bound_ff   <= bound_in;
      sum_ff     <= sum_in;
      bkt_ff     <= bkt_in;
   end

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = (state_ff == S_OUT);
   assign rsp_ch.payload = rsp_ff;

`ifndef SYNTH
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != S_IDLE))
      else $error("accepted transaction did not start work");
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.range_error) |->
      (rsp_ch.payload.total_sum == '0 && !rsp_ch.payload.quantile_valid))
      else $error("range error response carries data");
   a_valid_has_samples: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.payload.quantile_valid) |->
      (rsp_ch.payload.sample_count != '0))
      else $error("quantile valid without samples");
   a_sweep_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !req_ch.ready)
      else $error("ready during post-reset sweep");
`endif
endmodule

// ===== verif/tb_stat_counters_log2_histogram_core.sv =====
`timescale 1ns / 100ps

module tb_stat_counters_log2_histogram_core;
   import shist_pkg::*;

   localparam int N_DOM = 2;
   localparam int N_FLD = 40;
   localparam int N_BKT = 48;
   localparam int N_RANDOM = 650;
   localparam longint CYCLE_LIMIT = 64'd20000000;

   logic clock;
   logic reset;

   shist_req_if req_ch();
   shist_rsp_if rsp_ch();

   stat_counters_log2_histogram_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // shadow copy of the counter state
   logic [63:0] run_sum   [N_DOM][N_FLD];
   logic [63:0] bat_sum   [N_DOM][N_FLD];
   logic [63:0] run_hist  [N_DOM][N_FLD][N_BKT];
   logic [63:0] bat_hist  [N_DOM][N_FLD][N_BKT];
   logic [N_FLD-1:0] run_seen [N_DOM];
   logic [N_FLD-1:0] bat_seen [N_DOM];
   logic [63:0] dom_gen   [N_DOM];

   rsp_type expected_rsp_q[$];
   int      error_count;
   longint  cycle_count;
   bit      stim_done;
   bit      idle_enable;
   bit      hold_rsp;
   bit      hold_started;

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   task automatic clear_counters();
      for (int d = 0; d < N_DOM; d++) begin
         for (int f = 0; f < N_FLD; f++) begin
            run_sum[d][f] = '0;
            bat_sum[d][f] = '0;
            for (int b = 0; b < N_BKT; b++) begin
               run_hist[d][f][b] = '0;
               bat_hist[d][f][b] = '0;
            end
         end
         run_seen[d] = '0;
         bat_seen[d] = '0;
         dom_gen[d]  = '0;
      end
   endtask

   function automatic int log2_bucket(input logic [63:0] v);
      int len;
      len = 0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            len = i + 1;
         end
      end
      return (len < N_BKT) ? len : N_BKT - 1;
   endfunction

   // update shadow state and compute the response for one transaction
   task automatic predict_stats(input req_type rq, output rsp_type rs);
      int d, f, bk;
      logic [63:0] hist[N_BKT];
      logic [63:0] samples, running, target, q, r;
      rs = '0;
      if (rq.cmd == CMD_CLEAR) begin
         clear_counters();
      end
      if (int'(rq.domain) >= N_DOM || int'(rq.field) >= N_FLD) begin
         rs.range_error = 1'b1;
         return;
      end
      d = int'(rq.domain);
      f = int'(rq.field);
      if (rq.cmd == CMD_ADD || rq.cmd == CMD_OBSERVE) begin
         // generation rollover clears the batch view of the domain
         if (dom_gen[d] != rq.batch_gen) begin
            for (int i = 0; i < N_FLD; i++) begin
               bat_sum[d][i] = '0;
               for (int b = 0; b < N_BKT; b++) begin
                  bat_hist[d][i][b] = '0;
               end
            end
            bat_seen[d] = '0;
            dom_gen[d] = rq.batch_gen;
         end
         run_sum[d][f] += rq.value;
         bat_sum[d][f] += rq.value;
         run_seen[d][f] = 1'b1;
         bat_seen[d][f] = 1'b1;
         if (rq.cmd == CMD_OBSERVE) begin
            bk = log2_bucket(rq.value);
            run_hist[d][f][bk] += 1;
            bat_hist[d][f][bk] += 1;
         end
      end
      samples = '0;
      for (int b = 0; b < N_BKT; b++) begin
         hist[b] = rq.use_last ? bat_hist[d][f][b] : run_hist[d][f][b];
         samples += hist[b];
      end
      // percentile search over the buckets
      if (samples != 0 && rq.percentile <= PCT_MAX) begin
         q = samples / 100;
         r = samples % 100;
         target = q * rq.percentile + (r * rq.percentile + 99) / 100;
         running = '0;
         for (int b = 0; b < N_BKT; b++) begin
            running += hist[b];
            if (running >= target) begin
               rs.quantile_bound = (b == 0) ? '0 : BOUND_W'((64'd1 << b) - 1);
               rs.quantile_valid = 1'b1;
               break;
            end
         end
      end
      rs.total_sum = rq.use_last ? bat_sum[d][f] : run_sum[d][f];
      rs.seen_flag = rq.use_last ? bat_seen[d][f] : run_seen[d][f];
      rs.sample_count = samples;
      rs.stored_generation = dom_gen[d];
   endtask

   // send one transaction; fixed rows check the prediction against the table result
   task automatic send_req(input req_type rq, input bit fixed, input rsp_type fixed_rsp);
      rsp_type rs;
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.payload <= rq;
      req_ch.valid   <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_stats(rq, rs);
      if (fixed && rs !== fixed_rsp) begin
         report_mismatch("directed row prediction", rs[63:0], fixed_rsp[63:0]);
      end
      expected_rsp_q.push_back(rs);
      @(negedge clock);
   endtask

   function automatic req_type make_req(input cmd_type c, input logic dom,
                                        input logic [5:0] fld, input logic [63:0] val,
                                        input logic [63:0] gen, input logic last,
                                        input logic [6:0] pct);
      req_type rq;
      rq.cmd = c;
      rq.domain = dom;
      rq.field = fld;
      rq.value = val;
      rq.batch_gen = gen;
      rq.use_last = last;
      rq.percentile = pct;
      return rq;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [63:0] rand_value();
      int sel;
      sel = $urandom_range(0, 5);
      case (sel)
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(0, 63);
         3: return rand64() >> $urandom_range(0, 63);
         default: return 64'($urandom_range(0, 5000));
      endcase
   endfunction

   // directed table
   typedef struct {
      req_type rq;
      bit      fixed;
      rsp_type rs;
   } dir_row_type;

   dir_row_type dir_rows[$];

   task automatic add_row(input req_type rq, input bit fixed, input rsp_type rs);
      dir_row_type row;
      row.rq = rq;
      row.fixed = fixed;
      row.rs = rs;
      dir_rows.push_back(row);
   endtask

   task automatic build_directed();
      rsp_type z, e;
      z = '0;
      // read after reset shows all zero
      add_row(make_req(CMD_READ, 1'b0, 6'd0, '1, '1, 1'b0, 7'd50), 1, z);
      // out of range fields
      e = '0;
      e.range_error = 1'b1;
      add_row(make_req(CMD_ADD, 1'b1, 6'd40, '1, '1, 1'b1, 7'd127), 1, e);
      add_row(make_req(CMD_OBSERVE, 1'b0, 6'd63, 64'd5, 64'd1, 1'b0, 7'd0), 1, e);
      // add max value at generation zero
      e = '0;
      e.total_sum = '1;
      e.seen_flag = 1'b1;
      add_row(make_req(CMD_ADD, 1'b0, 6'd39, '1, '0, 1'b0, 7'd100), 1, e);
      add_row(make_req(CMD_ADD, 1'b0, 6'd39, 64'd2, '0, 1'b0, 7'd100), 0, z);
      // observe extremes: zero, one, max, capped bucket
      add_row(make_req(CMD_OBSERVE, 1'b1, 6'd0, 64'd0, 64'd7, 1'b1, 7'd100), 0, z);
      add_row(make_req(CMD_OBSERVE, 1'b1, 6'd0, 64'd1, 64'd7, 1'b1, 7'd50), 0, z);
      add_row(make_req(CMD_OBSERVE, 1'b1, 6'd0, '1, 64'd7, 1'b0, 7'd100), 0, z);
      add_row(make_req(CMD_OBSERVE, 1'b1, 6'd0, 64'd1 << 46, 64'd7, 1'b1, 7'd99), 0, z);
      add_row(make_req(CMD_OBSERVE, 1'b1, 6'd0, 64'd1 << 47, 64'd7, 1'b1, 7'd0), 0, z);
      // percentile above 100 and reads of both views
      add_row(make_req(CMD_READ, 1'b1, 6'd0, '0, 64'd9, 1'b1, 7'd101), 0, z);
      add_row(make_req(CMD_READ, 1'b1, 6'd0, '0, 64'd9, 1'b0, 7'd127), 0, z);
      add_row(make_req(CMD_READ, 1'b1, 6'd0, '0, 64'd9, 1'b1, 7'd1), 0, z);
      // generation rollover clears batch view
      add_row(make_req(CMD_ADD, 1'b1, 6'd5, 64'd3, '1, 1'b1, 7'd50), 0, z);
      add_row(make_req(CMD_READ, 1'b1, 6'd0, '0, '0, 1'b1, 7'd50), 0, z);
      add_row(make_req(CMD_READ, 1'b1, 6'd0, '0, '0, 1'b0, 7'd50), 0, z);
      // clear everything then read
      add_row(make_req(CMD_CLEAR, 1'b0, 6'd39, '1, '1, 1'b0, 7'd50), 1, z);
      add_row(make_req(CMD_READ, 1'b1, 6'd0, '1, '1, 1'b1, 7'd100), 1, z);
      e = '0;
      e.range_error = 1'b1;
      add_row(make_req(CMD_CLEAR, 1'b1, 6'd50, '0, '0, 1'b1, 7'd0), 1, e);
   endtask

   function automatic req_type rand_req(input logic [63:0] gen_a, input logic [63:0] gen_b);
      req_type rq;
      int pick;
      pick = $urandom_range(0, 99);
      rq.cmd = (pick < 35) ? CMD_ADD : (pick < 75) ? CMD_OBSERVE :
               (pick < 99) ? CMD_READ : CMD_CLEAR;
      rq.domain = 1'($urandom_range(0, 1));
      // mostly a few hot fields so histograms fill up, some out of range
      pick = $urandom_range(0, 19);
      rq.field = (pick == 0) ? 6'($urandom_range(40, 63)) :
                 (pick < 14) ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 39));
      rq.value = rand_value();
      rq.batch_gen = rq.domain ? gen_b : gen_a;
      rq.use_last = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      rq.percentile = (pick == 0) ? 7'($urandom_range(101, 127)) :
                      (pick == 1) ? PCT_MAX : 7'($urandom_range(0, 100));
      return rq;
   endfunction

   // stimulus
   initial begin
      req_type rq;
      logic [63:0] gen_a, gen_b;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      error_count = 0;
      stim_done = 1'b0;
      idle_enable = 1'b1;
      hold_started = 1'b0;
      clear_counters();
      build_directed();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         send_req(dir_rows[i].rq, dir_rows[i].fixed, dir_rows[i].rs);
      end
      gen_a = 64'd1;
      gen_b = '1;
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n == N_RANDOM - 100) begin
            idle_enable = 1'b0;
         end
         if (n == 40) begin
            hold_started = 1'b1;
         end
         // occasional generation changes, sometimes random wide values
         if ($urandom_range(0, 39) == 0) begin
            gen_a = ($urandom_range(0, 1)) ? rand64() : gen_a + 1;
         end
         if ($urandom_range(0, 39) == 0) begin
            gen_b = ($urandom_range(0, 3) == 0) ? '0 : rand64();
         end
         rq = rand_req(gen_a, gen_b);
         send_req(rq, 0, '0);
      end
      req_ch.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      int held;
      hold_rsp = 1'b0;
      wait (hold_started);
      @(negedge clock);
      hold_rsp = 1'b1;
      held = 0;
      while (held < 600) begin
         @(negedge clock);
         held++;
      end
      hold_rsp = 1'b0;
   end

   // response side ready with random stall bursts
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_ch.ready <= !hold_rsp;
            @(negedge clock);
         end
      end
   end

   // response checking
   always @(posedge clock) begin
      rsp_type exp_rs, got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("unexpected transaction", got.total_sum, '0);
         end else begin
            exp_rs = expected_rsp_q.pop_front();
            if (got.total_sum !== exp_rs.total_sum)
               report_mismatch("total_sum", got.total_sum, exp_rs.total_sum);
            if (got.seen_flag !== exp_rs.seen_flag)
               report_mismatch("seen_flag", 64'(got.seen_flag), 64'(exp_rs.seen_flag));
            if (got.sample_count !== exp_rs.sample_count)
               report_mismatch("sample_count", got.sample_count, exp_rs.sample_count);
            if (got.quantile_bound !== exp_rs.quantile_bound)
               report_mismatch("quantile_bound", 64'(got.quantile_bound),
                               64'(exp_rs.quantile_bound));
            if (got.quantile_valid !== exp_rs.quantile_valid)
               report_mismatch("quantile_valid", 64'(got.quantile_valid),
                               64'(exp_rs.quantile_valid));
            if (got.stored_generation !== exp_rs.stored_generation)
               report_mismatch("stored_generation", got.stored_generation,
                               exp_rs.stored_generation);
            if (got.range_error !== exp_rs.range_error)
               report_mismatch("range_error", 64'(got.range_error), 64'(exp_rs.range_error));
         end
      end
   end

   // end of run and timeout
   initial begin
      cycle_count = 0;
      while (!(stim_done && expected_rsp_q.size() == 0) && cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("stat_counters_log2_histogram_core regression: fail");
      end else begin
         repeat (400) @(posedge clock);
         if (error_count == 0) begin
            $display("stat_counters_log2_histogram_core regression: pass");
         end else begin
            $display("stat_counters_log2_histogram_core regression: fail");
         end
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/shist_pkg.sv
rtl/shist_if.sv
rtl/shist_ram.sv
rtl/stat_counters_log2_histogram_core.sv
verif/tb_stat_counters_log2_histogram_core.sv
